// ----- sv/dpdl_pkg.sv -----
package dpdl_pkg;

	localparam int CNT_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int BAND_W    = 8;
	localparam int DRV_W     = 32;
	localparam int FRAC_W    = 12;

	// heading error, distance error and its step, in whole counts
	localparam int E_W       = 18;
	localparam int D_W       = 17;
	localparam int DD_W      = 18;
	localparam int EDIFF_W   = 19;

	// products and sums, exact but for the heading correction, which drops FRAC_W bits
	localparam int HP_W      = E_W + GAIN_W + 1;
	localparam int HV_W      = EDIFF_W + GAIN_W + 1;
	localparam int HACC_W    = HV_W + 1;
	localparam int HCORR_W   = HACC_W - FRAC_W;
	localparam int DP_W      = D_W + GAIN_W + 1;
	localparam int DV_W      = DD_W + GAIN_W + 1;
	localparam int DACC_W    = DV_W + 1;
	localparam int DSUM_W    = DACC_W + 2;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GOAL_DISTANCE = 3'd0,
		REG_GOAL_ANGLE    = 3'd1,
		REG_HEADING_KP    = 3'd2,
		REG_HEADING_KD    = 3'd3,
		REG_DISTANCE_KP   = 3'd4,
		REG_DISTANCE_KD   = 3'd5,
		REG_DONE_BAND     = 3'd6
	} cfg_idx_t;

	localparam logic [GAIN_W-1:0] RST_HEADING_KP  = 16'd410;
	localparam logic [GAIN_W-1:0] RST_HEADING_KD  = 16'd819;
	localparam logic [GAIN_W-1:0] RST_DISTANCE_KP = 16'd1229;
	localparam logic [GAIN_W-1:0] RST_DISTANCE_KD = 16'd1229;
	localparam logic [BAND_W-1:0] RST_DONE_BAND   = 8'd2;

	typedef struct packed {
		logic signed [CNT_W-1:0] goal_distance;
		logic signed [CNT_W-1:0] goal_angle;
		logic [GAIN_W-1:0]       heading_kp;
		logic [GAIN_W-1:0]       heading_kd;
		logic [GAIN_W-1:0]       distance_kp;
		logic [GAIN_W-1:0]       distance_kd;
		logic [BAND_W-1:0]       done_band;
	} cfg_t;

	// load strobes, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	typedef struct packed {
		logic heading;
		logic distance;
	} flags_t;

endpackage

// ----- sv/dpdl_cfg.sv -----
module dpdl_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dpdl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpdl_pkg::GAIN_W-1:0]       cfg_data,
	output dpdl_pkg::cfg_t                    cfg_regs
);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs.goal_distance <= '0;
			cfg_regs.goal_angle    <= '0;
			cfg_regs.heading_kp    <= dpdl_pkg::RST_HEADING_KP;
			cfg_regs.heading_kd    <= dpdl_pkg::RST_HEADING_KD;
			cfg_regs.distance_kp   <= dpdl_pkg::RST_DISTANCE_KP;
			cfg_regs.distance_kd   <= dpdl_pkg::RST_DISTANCE_KD;
			cfg_regs.done_band     <= dpdl_pkg::RST_DONE_BAND;
		end else if (cfg_valid) begin
			case (dpdl_pkg::cfg_idx_t'(cfg_index))
				dpdl_pkg::REG_GOAL_DISTANCE: cfg_regs.goal_distance <= cfg_data;
				dpdl_pkg::REG_GOAL_ANGLE:    cfg_regs.goal_angle    <= cfg_data;
				dpdl_pkg::REG_HEADING_KP:    cfg_regs.heading_kp    <= cfg_data;
				dpdl_pkg::REG_HEADING_KD:    cfg_regs.heading_kd    <= cfg_data;
				dpdl_pkg::REG_DISTANCE_KP:   cfg_regs.distance_kp   <= cfg_data;
				dpdl_pkg::REG_DISTANCE_KD:   cfg_regs.distance_kd   <= cfg_data;
				dpdl_pkg::REG_DONE_BAND:
					cfg_regs.done_band <= cfg_data[dpdl_pkg::BAND_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/dpdl_front.sv -----
module dpdl_front #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dpdl_pkg::stage_en_t                     en,
	input  dpdl_pkg::cfg_t                          cfg_regs,
	input  logic                                    func,
	input  logic signed [dpdl_pkg::CNT_W-1:0]       left_count,
	input  logic signed [dpdl_pkg::CNT_W-1:0]       right_count,
	output logic                                    func_s2,
	output logic signed [dpdl_pkg::E_W-1:0]         e_s2,
	output logic signed [dpdl_pkg::D_W-1:0]         d_s2,
	output logic signed [dpdl_pkg::DD_W-1:0]        dd_s2,
	output logic [dpdl_pkg::E_W+$clog2(HISTORY_DEPTH)-2:0] sum_mag_s2,
	output logic                                    sum_neg_s2,
	output dpdl_pkg::flags_t                        flags_s2
);

	localparam int E_W   = dpdl_pkg::E_W;
	localparam int D_W   = dpdl_pkg::D_W;
	localparam int SUM_W = E_W + $clog2(HISTORY_DEPTH);
	localparam int MAG_W = SUM_W - 1;

	logic                          func_s1;
	logic signed [dpdl_pkg::CNT_W-1:0] left_s1;
	logic signed [dpdl_pkg::CNT_W-1:0] right_s1;

	logic signed [E_W-1:0]   hist_q [HISTORY_DEPTH];
	logic signed [SUM_W-1:0] sum_q;
	logic signed [D_W-1:0]   prev_q;
	dpdl_pkg::flags_t        flags_q;

	logic signed [D_W-1:0]   lr_diff;
	logic signed [D_W-1:0]   lr_sum;
	logic signed [D_W-1:0]   lr_sum_adj;
	logic signed [dpdl_pkg::CNT_W-1:0] lr_half;
	logic signed [E_W-1:0]   e;
	logic signed [D_W-1:0]   d;
	logic [E_W-1:0]          e_mag;
	logic [D_W-1:0]          d_mag;
	logic signed [SUM_W-1:0] sum_abs;
	dpdl_pkg::flags_t        flags_new;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			func_s1  <= func;
			left_s1  <= left_count;
			right_s1 <= right_count;
		end
	end

	always_comb begin
		lr_diff    = D_W'(left_s1) - D_W'(right_s1);
		lr_sum     = D_W'(left_s1) + D_W'(right_s1);
		// halve towards zero
		lr_sum_adj = lr_sum + D_W'({1'b0, lr_sum[D_W-1]});
		lr_half    = lr_sum_adj[D_W-1:1];
		e          = E_W'($signed(cfg_regs.goal_angle)) - E_W'(lr_diff);
		d          = D_W'($signed(cfg_regs.goal_distance)) - D_W'(lr_half);
		e_mag      = e[E_W-1] ? E_W'(-e) : E_W'(e);
		d_mag      = d[D_W-1] ? D_W'(-d) : D_W'(d);
		sum_abs    = sum_q[SUM_W-1] ? -sum_q : sum_q;
		flags_new.heading  = flags_q.heading  || (e_mag < E_W'(cfg_regs.done_band));
		flags_new.distance = flags_q.distance || (d_mag < D_W'(cfg_regs.done_band));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HISTORY_DEPTH; k++)
				hist_q[k] <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
			flags_q <= '0;
		end else if (en.s2) begin
			if (func_s1) begin
				for (int k = 0; k < HISTORY_DEPTH; k++)
					hist_q[k] <= '0;
				sum_q   <= '0;
				prev_q  <= '0;
				flags_q <= '0;
			end else begin
				for (int k = 1; k < HISTORY_DEPTH; k++)
					hist_q[k] <= hist_q[k-1];
				hist_q[0] <= e;
				sum_q     <= sum_q + SUM_W'(e) - SUM_W'(hist_q[HISTORY_DEPTH-1]);
				prev_q    <= d;
				flags_q   <= flags_new;
			end
		end
	end

	// the mean uses the sum as it stood before this item
	always_ff @(posedge clk) begin
		if (en.s2) begin
			func_s2    <= func_s1;
			e_s2       <= e;
			d_s2       <= d;
			dd_s2      <= dpdl_pkg::DD_W'(d) - dpdl_pkg::DD_W'(prev_q);
			sum_mag_s2 <= sum_abs[MAG_W-1:0];
			sum_neg_s2 <= sum_q[SUM_W-1];
			flags_s2   <= func_s1 ? '0 : flags_new;
		end
	end

endmodule

// ----- sv/dpdl_gain.sv -----
module dpdl_gain #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                                    clk,
	input  dpdl_pkg::stage_en_t                     en,
	input  dpdl_pkg::cfg_t                          cfg_regs,
	input  logic                                    func_s2,
	input  logic signed [dpdl_pkg::E_W-1:0]         e_s2,
	input  logic signed [dpdl_pkg::D_W-1:0]         d_s2,
	input  logic signed [dpdl_pkg::DD_W-1:0]        dd_s2,
	input  logic [dpdl_pkg::E_W+$clog2(HISTORY_DEPTH)-2:0] sum_mag_s2,
	input  logic                                    sum_neg_s2,
	input  dpdl_pkg::flags_t                        flags_s2,
	output logic                                    func_s5,
	output logic signed [dpdl_pkg::HCORR_W-1:0]     hcorr_s5,
	output logic signed [dpdl_pkg::DACC_W-1:0]      dacc_s5,
	output dpdl_pkg::flags_t                        flags_s5
);

	localparam int E_W     = dpdl_pkg::E_W;
	localparam int MAG_W   = E_W + $clog2(HISTORY_DEPTH) - 1;
	// floor(m * RECIP / 2^SHIFT) equals floor(m / depth) for every m below 2^MAG_W
	localparam int SHIFT   = MAG_W + $clog2(HISTORY_DEPTH);
	localparam longint RECIP = ((64'd1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
	localparam int RECIP_W = MAG_W + 1;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam int QUOT_W  = E_W - 1;

	localparam int HACC_W  = dpdl_pkg::HACC_W;
	localparam int FRAC_W  = dpdl_pkg::FRAC_W;

	logic [PROD_W-1:0]                       prod;
	logic signed [dpdl_pkg::DP_W-1:0]        dp;
	logic signed [dpdl_pkg::DV_W-1:0]        dv;

	logic                                    func_s3;
	logic signed [E_W-1:0]                   e_s3;
	logic [QUOT_W-1:0]                       quot_s3;
	logic                                    neg_s3;
	logic signed [dpdl_pkg::DP_W-1:0]        dp_s3;
	logic signed [dpdl_pkg::DV_W-1:0]        dv_s3;
	dpdl_pkg::flags_t                        flags_s3;

	logic signed [E_W-1:0]                   mean_mag;
	logic signed [E_W-1:0]                   mean;
	logic signed [dpdl_pkg::EDIFF_W-1:0]     ediff;
	logic signed [dpdl_pkg::HP_W-1:0]        hp;
	logic signed [dpdl_pkg::HV_W-1:0]        hv;

	logic                                    func_s4;
	logic signed [dpdl_pkg::HP_W-1:0]        hp_s4;
	logic signed [dpdl_pkg::HV_W-1:0]        hv_s4;
	logic signed [dpdl_pkg::DACC_W-1:0]      dacc_s4;
	dpdl_pkg::flags_t                        flags_s4;

	logic signed [HACC_W-1:0]                hacc;
	logic signed [HACC_W-1:0]                hacc_adj;

	// stage 3: mean magnitude by reciprocal, distance products
	assign prod = sum_mag_s2 * RECIP_W'(RECIP);
	assign dp   = $signed({1'b0, cfg_regs.distance_kp}) * d_s2;
	assign dv   = $signed({1'b0, cfg_regs.distance_kd}) * dd_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			func_s3  <= func_s2;
			e_s3     <= e_s2;
			quot_s3  <= prod[SHIFT +: QUOT_W];
			neg_s3   <= sum_neg_s2;
			dp_s3    <= dp;
			dv_s3    <= dv;
			flags_s3 <= flags_s2;
		end
	end

	// stage 4: signed mean, heading products, distance sum
	always_comb begin
		mean_mag = $signed({1'b0, quot_s3});
		mean     = neg_s3 ? -mean_mag : mean_mag;
		ediff    = dpdl_pkg::EDIFF_W'(e_s3) - dpdl_pkg::EDIFF_W'(mean);
	end

	assign hp = $signed({1'b0, cfg_regs.heading_kp}) * e_s3;
	assign hv = $signed({1'b0, cfg_regs.heading_kd}) * ediff;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			func_s4  <= func_s3;
			hp_s4    <= hp;
			hv_s4    <= hv;
			dacc_s4  <= dpdl_pkg::DACC_W'(dp_s3) + dpdl_pkg::DACC_W'(dv_s3);
			flags_s4 <= flags_s3;
		end
	end

	// stage 5: heading correction to whole counts, towards zero
	always_comb begin
		hacc     = HACC_W'(hp_s4) + HACC_W'(hv_s4);
		hacc_adj = hacc + (hacc[HACC_W-1] ? HACC_W'((1 << FRAC_W) - 1) : HACC_W'(0));
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			func_s5  <= func_s4;
			hcorr_s5 <= hacc_adj[HACC_W-1:FRAC_W];
			dacc_s5  <= dacc_s4;
			flags_s5 <= flags_s4;
		end
	end

endmodule

// ----- sv/dpdl_drive.sv -----
module dpdl_drive (
	input  logic                                    clk,
	input  dpdl_pkg::stage_en_t                     en,
	input  logic                                    func_s5,
	input  logic signed [dpdl_pkg::HCORR_W-1:0]     hcorr_s5,
	input  logic signed [dpdl_pkg::DACC_W-1:0]      dacc_s5,
	input  dpdl_pkg::flags_t                        flags_s5,
	output logic signed [dpdl_pkg::DRV_W-1:0]       left_drive_s6,
	output logic signed [dpdl_pkg::DRV_W-1:0]       right_drive_s6,
	output dpdl_pkg::flags_t                        flags_s6
);

	localparam int DSUM_W = dpdl_pkg::DSUM_W;
	localparam int DRV_W  = dpdl_pkg::DRV_W;

	logic signed [DSUM_W-1:0] hshift;
	logic signed [DSUM_W-1:0] lsum;
	logic signed [DSUM_W-1:0] rsum;

	function automatic logic signed [DRV_W-1:0] clamp(input logic signed [DSUM_W-1:0] v);
		logic fits;
		fits = (v[DSUM_W-1:DRV_W-1] == '0) || (v[DSUM_W-1:DRV_W-1] == '1);
		if (fits)
			clamp = v[DRV_W-1:0];
		else if (v[DSUM_W-1])
			clamp = {1'b1, {(DRV_W-1){1'b0}}};
		else
			clamp = {1'b0, {(DRV_W-1){1'b1}}};
	endfunction

	always_comb begin
		hshift = DSUM_W'($signed({hcorr_s5, {dpdl_pkg::FRAC_W{1'b0}}}));
		lsum   = DSUM_W'(dacc_s5) + hshift;
		rsum   = DSUM_W'(dacc_s5) - hshift;
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			left_drive_s6  <= func_s5 ? '0 : clamp(lsum);
			right_drive_s6 <= func_s5 ? '0 : clamp(rsum);
			flags_s6       <= flags_s5;
		end
	end

endmodule

// ----- sv/dual_pd_heading_distance_loop_top.sv -----
// Channel   Direction  Signals                                  Payload
// s_        in         s_tvalid s_tready s_tdata s_tuser       encoder counts, restart flag
// m_        out        m_tvalid m_tready m_tdata m_tuser       motor drives, done flags
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// One item per cycle sustained while m_tready stays high; each item passes
// through six register stages (input, error/state update, mean and distance
// products, heading products, heading correction, drive clamp).
// Reset clears the heading history, its running sum, the previous distance
// error, the done flags and the pipeline; registers return to their defaults.
// A stalled output holds its stage; earlier stages keep filling bubbles, so up
// to six items are in flight and s_tready falls only once all stages are full.
module dual_pd_heading_distance_loop_top #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // left_count[15:0], right_count[31:16]
	input  logic [0:0]  s_tuser,     // func[0]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,     // left_drive[31:0], right_drive[63:32]
	output logic [2:0]  m_tuser,     // heading_done[0], distance_done[1], goal_reached[2]

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dpdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpdl_pkg::GAIN_W-1:0]    cfg_data
);

	localparam int MAG_W = dpdl_pkg::E_W + $clog2(HISTORY_DEPTH) - 1;

	dpdl_pkg::cfg_t      cfg_regs;
	dpdl_pkg::stage_en_t en;

	logic [6:1] v_q;
	logic [6:1] vin;
	logic [7:1] free;
	logic [6:1] ld;

	logic                                    func_s2;
	logic signed [dpdl_pkg::E_W-1:0]         e_s2;
	logic signed [dpdl_pkg::D_W-1:0]         d_s2;
	logic signed [dpdl_pkg::DD_W-1:0]        dd_s2;
	logic [MAG_W-1:0]                        sum_mag_s2;
	logic                                    sum_neg_s2;
	dpdl_pkg::flags_t                        flags_s2;

	logic                                    func_s5;
	logic signed [dpdl_pkg::HCORR_W-1:0]     hcorr_s5;
	logic signed [dpdl_pkg::DACC_W-1:0]      dacc_s5;
	dpdl_pkg::flags_t                        flags_s5;

	logic signed [dpdl_pkg::DRV_W-1:0]       left_drive_s6;
	logic signed [dpdl_pkg::DRV_W-1:0]       right_drive_s6;
	dpdl_pkg::flags_t                        flags_s6;

	// a stage takes a new item when it is empty or its item moves on
	always_comb begin
		vin[1]   = s_tvalid;
		vin[6:2] = v_q[5:1];
		free[7]  = m_tready;
		for (int k = 6; k >= 1; k--)
			free[k] = !v_q[k] || free[k+1];
		ld = free[6:1] & vin;
	end

	assign en = '{s1: ld[1], s2: ld[2], s3: ld[3], s4: ld[4], s5: ld[5], s6: ld[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (free[6:1] & vin) | (~free[6:1] & v_q);
		end
	end

	assign s_tready = free[1];
	assign m_tvalid = v_q[6];

	dpdl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_regs  (cfg_regs)
	);

	dpdl_front #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cfg_regs    (cfg_regs),
		.func        (s_tuser[0]),
		.left_count  (s_tdata[15:0]),
		.right_count (s_tdata[31:16]),
		.func_s2     (func_s2),
		.e_s2        (e_s2),
		.d_s2        (d_s2),
		.dd_s2       (dd_s2),
		.sum_mag_s2  (sum_mag_s2),
		.sum_neg_s2  (sum_neg_s2),
		.flags_s2    (flags_s2)
	);

	dpdl_gain #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_gain (
		.clk        (clk),
		.en         (en),
		.cfg_regs   (cfg_regs),
		.func_s2    (func_s2),
		.e_s2       (e_s2),
		.d_s2       (d_s2),
		.dd_s2      (dd_s2),
		.sum_mag_s2 (sum_mag_s2),
		.sum_neg_s2 (sum_neg_s2),
		.flags_s2   (flags_s2),
		.func_s5    (func_s5),
		.hcorr_s5   (hcorr_s5),
		.dacc_s5    (dacc_s5),
		.flags_s5   (flags_s5)
	);

	dpdl_drive u_drive (
		.clk            (clk),
		.en             (en),
		.func_s5        (func_s5),
		.hcorr_s5       (hcorr_s5),
		.dacc_s5        (dacc_s5),
		.flags_s5       (flags_s5),
		.left_drive_s6  (left_drive_s6),
		.right_drive_s6 (right_drive_s6),
		.flags_s6       (flags_s6)
	);

	assign m_tdata = {right_drive_s6, left_drive_s6};
	assign m_tuser = {flags_s6.heading && flags_s6.distance, flags_s6.distance,
		flags_s6.heading};

endmodule
